/* sv/sac_pkg.sv */
// Package for the segment allocator: table sizes, codes and sequencer states.
// Used by segment_allocator_with_compaction; depends on nothing.
package sac_pkg;
	localparam int MAX_SEG = 32;
	localparam int IDX_W = 5;
	localparam int CNT_W = 6;
	localparam logic [20:0] MEM_BYTES = 21'h100000;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_ACCESS = 2'd1,
		OP_RELEASE = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_SEGV = 2'd1,
		ST_OVERLOAD = 2'd2,
		ST_MOVE = 2'd3
	} status_t;

	localparam logic CFG_MODE = 1'b0;
	localparam logic CFG_MEM = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_FIND, S_MOVE, S_LOGIC, S_POS, S_INSERT,
		S_ACCESS, S_RELEASE
	} state_t;
endpackage

/* sv/segment_allocator_with_compaction.sv */
// Segment allocator: sorted segment table, first/worst fit gap search,
// compaction with move commands, access translate, program release.
// A decode state, then scans of one table entry per cycle unless a move waits
// for the output. An allocate: up to two gap scans, moves, logical address
// search, insert position; access and release: one scan. Up to 32 segments
// held. One request at a time. Async reset empties the table.
module segment_allocator_with_compaction import sac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// opcode[1:0], program_id[17:2], logical_base[49:18], offset[70:50],
	// amount[91:71], zero fill
	input  logic [95:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], address[33:2], move_source[53:34], move_length[74:54], zero fill
	output logic [79:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [20:0] cfg_data
);
	state_t state_q, state_d;

	logic        mode_q;
	logic [20:0] mem_q;
	logic [15:0] prog_q [MAX_SEG];
	logic [31:0] logi_q [MAX_SEG];
	logic [19:0] phys_q [MAX_SEG];
	logic [20:0] size_q [MAX_SEG];
	logic [CNT_W-1:0] count_q, idx_q, w_q;
	logic [31:0] next_q, cand_q;

	logic [1:0]  op_q;
	logic [15:0] pid_q;
	logic [31:0] base_q;
	logic [20:0] off_q, amt_q;

	logic [20:0] cur_q, best_q, best_at_q, place_q;
	logic        retry_q;

	logic [79:0] out_q;
	logic        last_q, mvalid_q;

	// comb signals
	logic        out_free, scan_end, emit, e_last, found;
	status_t     e_status;
	logic [31:0] e_addr;
	logic [19:0] e_src;
	logic [20:0] e_len;
	logic [IDX_W-1:0] ix;
	logic [20:0] mem_u, phys_e, start_c, gap, end_v, tail, best_f, at_f, place_f;
	logic        ff_hit;

	assign s_tready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid = mvalid_q;
	assign m_tdata = out_q;
	assign m_tlast = last_q;
	assign out_free = !mvalid_q || m_tready;
	assign scan_end = (idx_q == count_q);
	assign ix = idx_q[IDX_W-1:0];

	// gap arithmetic for the entry under the scan index
	always_comb begin
		mem_u = (mem_q > MEM_BYTES) ? MEM_BYTES : mem_q;
		phys_e = {1'b0, phys_q[ix]};
		start_c = (phys_e > mem_u) ? mem_u : phys_e;
		gap = (start_c > cur_q) ? start_c - cur_q : 21'd0;
		end_v = phys_e + size_q[ix];
		tail = (cur_q < mem_u) ? mem_u - cur_q : 21'd0;
		ff_hit = !mode_q && (gap >= amt_q);
		if (tail >= best_q) begin
			best_f = tail;
			at_f = cur_q;
		end else begin
			best_f = best_q;
			at_f = best_at_q;
		end
		found = mode_q ? (best_f >= amt_q) : (tail >= amt_q);
		place_f = mode_q ? at_f : cur_q;
	end

	// next state and result requests
	always_comb begin
		state_d = state_q;
		emit = 1'b0;
		e_status = ST_OK;
		e_addr = '0;
		e_src = '0;
		e_len = '0;
		e_last = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_DECODE;
			end
			S_DECODE: begin
				unique case (op_t'(op_q))
					OP_ALLOC: begin
						if (amt_q == '0 || count_q >= CNT_W'(MAX_SEG)) begin
							e_status = ST_OVERLOAD;
							emit = out_free;
							if (out_free) state_d = S_IDLE;
						end else begin
							state_d = S_FIND;
						end
					end
					OP_ACCESS: state_d = S_ACCESS;
					OP_RELEASE: state_d = S_RELEASE;
					default: begin
						e_status = ST_SEGV;
						emit = out_free;
						if (out_free) state_d = S_IDLE;
					end
				endcase
			end
			S_FIND: begin
				if (!scan_end) begin
					if (ff_hit) state_d = S_LOGIC;
				end else if (found) begin
					state_d = S_LOGIC;
				end else if (!retry_q) begin
					state_d = S_MOVE;
				end else begin
					e_status = ST_OVERLOAD;
					emit = out_free;
					if (out_free) state_d = S_IDLE;
				end
			end
			S_MOVE: begin
				if (scan_end) begin
					state_d = S_FIND;
				end else begin
					e_status = ST_MOVE;
					e_addr = {11'd0, cur_q};
					e_src = phys_q[ix];
					e_len = size_q[ix];
					e_last = 1'b0;
					emit = out_free;
				end
			end
			S_LOGIC: begin
				if (scan_end) state_d = S_POS;
			end
			S_POS: begin
				if (scan_end || {1'b0, phys_q[ix]} > place_q) state_d = S_INSERT;
			end
			S_INSERT: begin
				e_addr = cand_q;
				emit = out_free;
				if (out_free) state_d = S_IDLE;
			end
			S_ACCESS: begin
				if (scan_end) begin
					e_status = ST_SEGV;
					emit = out_free;
				end else if (prog_q[ix] == pid_q && logi_q[ix] == base_q) begin
					if ({1'b0, off_q} + {1'b0, amt_q} > {1'b0, size_q[ix]}) begin
						e_status = ST_SEGV;
					end else begin
						e_addr = {12'd0, phys_q[ix]};
					end
					emit = out_free;
				end
				if (emit) state_d = S_IDLE;
			end
			S_RELEASE: begin
				if (scan_end) begin
					emit = out_free;
					if (out_free) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration, control counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			mem_q <= MEM_BYTES;
			count_q <= '0;
			next_q <= '0;
			mvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_MODE) mode_q <= cfg_data[0];
				else mem_q <= cfg_data;
			end
			if (emit) mvalid_q <= 1'b1;
			else if (m_tready) mvalid_q <= 1'b0;
			if (state_q == S_LOGIC && scan_end) next_q <= cand_q + 32'd1;
			if (state_q == S_INSERT && out_free) count_q <= count_q + 1'b1;
			if (state_q == S_RELEASE && scan_end && out_free) count_q <= w_q;
		end
	end

	// table and sequencer datapath
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= {5'd0, e_len, e_src, e_addr, e_status};
			last_q <= e_last;
		end
		unique case (state_q)
			S_IDLE: begin
				op_q <= s_tdata[1:0];
				pid_q <= s_tdata[17:2];
				base_q <= s_tdata[49:18];
				off_q <= s_tdata[70:50];
				amt_q <= s_tdata[91:71];
				idx_q <= '0;
				w_q <= '0;
				cur_q <= '0;
				best_q <= '0;
				best_at_q <= '0;
				retry_q <= 1'b0;
			end
			S_FIND: begin
				if (!scan_end) begin
					if (ff_hit) begin
						place_q <= cur_q;
						cand_q <= next_q;
						idx_q <= '0;
					end else begin
						if (gap > best_q) begin
							best_q <= gap;
							best_at_q <= cur_q;
						end
						if (end_v > cur_q) cur_q <= end_v;
						idx_q <= idx_q + 1'b1;
					end
				end else if (found || !retry_q) begin
					// hold the scan result while an overload waits for the output
					place_q <= place_f;
					cand_q <= next_q;
					idx_q <= '0;
					cur_q <= '0;
					best_q <= '0;
					best_at_q <= '0;
					retry_q <= 1'b1;
				end
			end
			S_MOVE: begin
				if (scan_end) begin
					idx_q <= '0;
					cur_q <= '0;
				end else if (out_free) begin
					phys_q[ix] <= cur_q[19:0];
					cur_q <= cur_q + size_q[ix];
					idx_q <= idx_q + 1'b1;
				end
			end
			S_LOGIC: begin
				if (scan_end) begin
					idx_q <= '0;
				end else if (logi_q[ix] == cand_q) begin
					cand_q <= cand_q + 32'd1;
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_POS: begin
				if (!scan_end && {1'b0, phys_q[ix]} <= place_q) idx_q <= idx_q + 1'b1;
			end
			S_INSERT: begin
				if (out_free) begin
					for (int i = 1; i < MAX_SEG; i++) begin
						if (IDX_W'(i) > ix) begin
							prog_q[i] <= prog_q[i-1];
							logi_q[i] <= logi_q[i-1];
							phys_q[i] <= phys_q[i-1];
							size_q[i] <= size_q[i-1];
						end
					end
					prog_q[ix] <= pid_q;
					logi_q[ix] <= cand_q;
					phys_q[ix] <= place_q[19:0];
					size_q[ix] <= amt_q;
				end
			end
			S_ACCESS: begin
				// stay on a matching entry until its result is taken
				if (!scan_end && !(prog_q[ix] == pid_q && logi_q[ix] == base_q))
					idx_q <= idx_q + 1'b1;
			end
			S_RELEASE: begin
				if (!scan_end) begin
					if (prog_q[ix] != pid_q) begin
						prog_q[w_q[IDX_W-1:0]] <= prog_q[ix];
						logi_q[w_q[IDX_W-1:0]] <= logi_q[ix];
						phys_q[w_q[IDX_W-1:0]] <= phys_q[ix];
						size_q[w_q[IDX_W-1:0]] <= size_q[ix];
						w_q <= w_q + 1'b1;
					end
					idx_q <= idx_q + 1'b1;
				end
			end
			default: ;
		endcase
	end
endmodule

/* tb/sv/segment_allocator_with_compaction_tb.sv */
`timescale 1ns / 100ps
// Testbench for the segment allocator: random and directed requests, a behavioral
// table predictor and an in-order result checker. Depends on sac_pkg and the DUT.
module segment_allocator_with_compaction_tb;
	import sac_pkg::*;

	// Behavioral segment table and result checker
	class seg_scoreboard;
		bit        mode;
		bit [20:0] msize;
		int        count;
		bit [15:0] prog [MAX_SEG];
		bit [31:0] lbase [MAX_SEG];
		longint    pbase [MAX_SEG];
		longint    sz [MAX_SEG];
		bit [31:0] next_lb;
		bit [74:0] pending [$];
		bit        pend_last [$];
		int        errors;

		function new();
			mode = 0;
			msize = 21'h100000;
			count = 0;
			next_lb = 0;
			errors = 0;
		endfunction

		function void push(status_t st, bit [31:0] a, bit [19:0] s, bit [20:0] l, bit lst);
			pending.push_back({l, s, a, st});
			pend_last.push_back(lst);
		endfunction

		function bit find_gap(longint need, output longint place);
			longint mem, cursor, best, best_at, st, en, gap, tail;
			mem = (msize > MEM_BYTES) ? MEM_BYTES : msize;
			cursor = 0; best = 0; best_at = 0; place = 0;
			for (int i = 0; i < count; i++) begin
				st = pbase[i];
				en = pbase[i] + sz[i];
				if (st > mem) st = mem;
				gap = (st > cursor) ? st - cursor : 0;
				if (!mode) begin
					if (gap >= need) begin
						place = cursor;
						return 1;
					end
				end else if (gap > best) begin
					best = gap;
					best_at = cursor;
				end
				if (en > cursor) cursor = en;
			end
			tail = (cursor < mem) ? mem - cursor : 0;
			if (!mode) begin
				place = cursor;
				return tail >= need;
			end
			if (tail >= best) begin
				best = tail;
				best_at = cursor;
			end
			place = best_at;
			return best >= need;
		endfunction

		function bit lb_used(bit [31:0] v);
			for (int i = 0; i < count; i++)
				if (lbase[i] == v) return 1;
			return 0;
		endfunction

		// Note an accepted request and queue its expected results
		function void note_request(op_t op, bit [15:0] pid, bit [31:0] lb, bit [20:0] off,
				bit [20:0] amt);
			longint place, cur;
			bit ok, hit;
			bit [31:0] lg;
			int pos, w;
			case (op)
				OP_ALLOC: begin
					if (amt == 0 || count >= MAX_SEG) begin
						push(ST_OVERLOAD, 0, 0, 0, 1);
						return;
					end
					ok = find_gap(amt, place);
					if (!ok) begin
						cur = 0;
						for (int i = 0; i < count; i++) begin
							push(ST_MOVE, 32'(cur), 20'(pbase[i]), 21'(sz[i]), 0);
							pbase[i] = cur;
							cur += sz[i];
						end
						ok = find_gap(amt, place);
					end
					if (!ok) begin
						push(ST_OVERLOAD, 0, 0, 0, 1);
						return;
					end
					lg = next_lb;
					while (lb_used(lg)) lg++;
					next_lb = lg + 1;
					pos = 0;
					while (pos < count && pbase[pos] <= place) pos++;
					for (int i = count; i > pos; i--) begin
						prog[i] = prog[i-1];
						lbase[i] = lbase[i-1];
						pbase[i] = pbase[i-1];
						sz[i] = sz[i-1];
					end
					prog[pos] = pid;
					lbase[pos] = lg;
					pbase[pos] = place;
					sz[pos] = amt;
					count++;
					push(ST_OK, lg, 0, 0, 1);
				end
				OP_ACCESS: begin
					hit = 0;
					for (int i = 0; i < count; i++)
						if (prog[i] == pid && lbase[i] == lb) begin
							if (longint'(off) + amt <= sz[i]) begin
								push(ST_OK, 32'(pbase[i]), 0, 0, 1);
								hit = 1;
							end
							break;
						end
					if (!hit) push(ST_SEGV, 0, 0, 0, 1);
				end
				OP_RELEASE: begin
					w = 0;
					for (int r = 0; r < count; r++)
						if (prog[r] != pid) begin
							prog[w] = prog[r];
							lbase[w] = lbase[r];
							pbase[w] = pbase[r];
							sz[w] = sz[r];
							w++;
						end
					count = w;
					push(ST_OK, 0, 0, 0, 1);
				end
				default: push(ST_SEGV, 0, 0, 0, 1);
			endcase
		endfunction

		// Compare one accepted result with the oldest expectation
		function void check_result(bit [79:0] d, bit lst);
			bit [74:0] e;
			bit el;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h last %b", d[74:0], lst);
				return;
			end
			e = pending.pop_front();
			el = pend_last.pop_front();
			if (e != d[74:0] || el != lst || d[79:75] != 0) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp st %0d addr %h src %h len %h last %b %s",
						e[1:0], e[33:2], e[53:34], e[74:54], el,
						$sformatf("/ got st %0d addr %h src %h len %h last %b",
						d[1:0], d[33:2], d[53:34], d[74:54], lst));
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [79:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic        cfg_index = 0;
	logic [20:0] cfg_data = '0;

	seg_scoreboard sb;
	bit hold_off = 0;
	bit [15:0] live_pids [$];
	bit [31:0] live_lbs [$];

	segment_allocator_with_compaction u_top (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// Short gaps mostly, a long one now and then
	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic write_reg(logic idx, logic [20:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == CFG_MODE) sb.mode = val[0];
		else sb.msize = val;
		@(posedge clk);
	endtask

	// Valid stays up between back-to-back requests; drain() drops it
	task automatic send_request(op_t op, bit [15:0] pid, bit [31:0] lb, bit [20:0] off,
			bit [20:0] amt, bit no_gap);
		int g;
		g = no_gap ? 0 : gap_len();
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_tdata <= {4'b0, amt, off, lb, pid, op};
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		sb.note_request(op, pid, lb, off, amt);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		s_tvalid <= 0;
		while (sb.pending.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (1200) @(posedge clk);
	endtask

	// Result side: random stalls plus one forced long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
			if (hold_off) m_tready <= 0;
			else m_tready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 4) == 0);
		end
	end

	// Random request with mostly sensible content
	task automatic random_request(bit no_gap);
		int r, k;
		bit [15:0] pid;
		bit [31:0] lb;
		bit [20:0] amt, off;
		r = $urandom_range(0, 99);
		pid = 16'($urandom_range(0, 5));
		if ($urandom_range(0, 19) == 0) pid = 16'($urandom);
		if (r < 45) begin
			k = $urandom_range(0, 9);
			amt = (k < 6) ? 21'($urandom_range(1, 60000))
				: (k < 8) ? 21'($urandom_range(1, 16))
				: (k == 8) ? 21'($urandom) : 21'h100000;
			send_request(OP_ALLOC, pid, $urandom, 21'($urandom), amt, no_gap);
		end else if (r < 80) begin
			lb = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 300) : $urandom;
			off = ($urandom_range(0, 3) != 0) ? 21'($urandom_range(0, 4000)) : 21'($urandom);
			amt = ($urandom_range(0, 3) != 0) ? 21'($urandom_range(0, 4000)) : 21'($urandom);
			send_request(OP_ACCESS, pid, lb, off, amt, no_gap);
		end else if (r < 95) begin
			send_request(OP_RELEASE, pid, $urandom, 21'($urandom), 21'($urandom), no_gap);
		end else begin
			send_request(OP_NONE, 16'($urandom), $urandom, 21'($urandom), 21'($urandom),
				no_gap);
		end
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: fill, access bounds, compaction, release, extremes
		write_reg(CFG_MODE, 0);
		write_reg(CFG_MEM, 21'd4096);
		send_request(OP_ALLOC, 16'd1, 0, 0, 0, 0);
		send_request(OP_ALLOC, 16'd1, 0, 0, 21'd1000, 0);
		send_request(OP_ALLOC, 16'd2, 0, 0, 21'd1000, 0);
		send_request(OP_ALLOC, 16'd1, 0, 0, 21'd1000, 0);
		send_request(OP_ACCESS, 16'd1, 32'd0, 21'd999, 21'd1, 0);
		send_request(OP_ACCESS, 16'd1, 32'd0, 21'd1000, 21'd1, 0);
		send_request(OP_ACCESS, 16'd2, 32'd0, 0, 0, 0);
		send_request(OP_ACCESS, 16'd2, 32'd1, 21'h1FFFFF, 21'h1FFFFF, 0);
		send_request(OP_RELEASE, 16'd2, 0, 0, 0, 0);
		send_request(OP_RELEASE, 16'hFFFF, 32'hFFFFFFFF, 21'h1FFFFF, 21'h1FFFFF, 0);
		send_request(OP_ALLOC, 16'd3, 0, 0, 21'd1500, 0);
		send_request(OP_ALLOC, 16'd3, 0, 0, 21'd5000, 0);
		send_request(OP_NONE, 16'hFFFF, 32'hFFFFFFFF, 21'h1FFFFF, 21'h1FFFFF, 0);
		drain();
		write_reg(CFG_MODE, 1);
		send_request(OP_ALLOC, 16'd4, 0, 0, 21'd200, 0);
		send_request(OP_RELEASE, 16'd1, 0, 0, 0, 0);
		send_request(OP_ALLOC, 16'd4, 0, 0, 21'd100, 0);
		drain();
		write_reg(CFG_MEM, 21'd100);
		send_request(OP_ALLOC, 16'd5, 0, 0, 21'd10, 0);
		drain();
		write_reg(CFG_MEM, 21'd0);
		send_request(OP_ALLOC, 16'd5, 0, 0, 21'd1, 0);
		drain();
		write_reg(CFG_MEM, 21'h1FFFFF);
		send_request(OP_ALLOC, 16'hFFFF, 0, 0, 21'h100000, 0);
		send_request(OP_RELEASE, 16'hFFFF, 0, 0, 0, 0);
		drain();

		// Random phases across settings; one with the result side held off
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_MODE, {20'd0, ph[0]});
			case (ph)
				0: write_reg(CFG_MEM, 21'h100000);
				1: write_reg(CFG_MEM, 21'd200000);
				2: write_reg(CFG_MEM, 21'd1);
				3: write_reg(CFG_MEM, 21'd300000);
				4: write_reg(CFG_MEM, 21'h1FFFFF);
				default: write_reg(CFG_MEM, 21'd120000);
			endcase
			if (ph == 1) begin
				fork
					begin
						hold_off = 1;
						repeat (3000) @(posedge clk);
						hold_off = 0;
					end
					for (int i = 0; i < 30; i++) random_request(1);
				join
			end
			for (int i = 0; i < 70; i++) random_request(i < 10);
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#40ms;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule

/* sim.f */
sv/sac_pkg.sv
sv/segment_allocator_with_compaction.sv
tb/sv/segment_allocator_with_compaction_tb.sv
